// ----- rtl/next_greater_distance_stack_macros.svh -----
// assertion macros for the next greater distance stack
`ifndef NEXT_GREATER_DISTANCE_STACK_MACROS_SVH
`define NEXT_GREATER_DISTANCE_STACK_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset
`define NGD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("next_greater_distance_stack: assertion failed");

// combinational condition that must never hold outside reset
`define NGD_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("next_greater_distance_stack: forbidden condition seen");

`else

`define NGD_ASSERT(label, prop)
`define NGD_ASSERT_NEVER(label, expr)

`endif

`endif

// ----- rtl/ngd_pkg.sv -----
// shared types for the next greater distance stack
package ngd_pkg;

  localparam int unsigned DataW = 16;

  // one stack entry held by a cell
  typedef struct packed {
    logic                    valid;
    logic [DataW-1:0]        idx;
    logic signed [DataW-1:0] val;
  } ngd_entry_t;

  // operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_CLEAR
  } ngd_op_e;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ngd_state_e;

endpackage

// ----- rtl/ngd_cell.sv -----
// one stack cell: holds an entry, shifts down on push and up on pop
module ngd_cell
  import ngd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ngd_op_e    op_i,
  input  ngd_entry_t above_i,
  input  ngd_entry_t below_i,
  output ngd_entry_t entry_o
);

  logic             valid_q, valid_d;
  logic [DataW-1:0] idx_q, idx_d;
  logic [DataW-1:0] val_q, val_d;
  logic             load;

  // next entry from the chain operation
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    val_d   = val_q;
    load    = 1'b0;
    case (op_i)
      OP_PUSH: begin
        valid_d = above_i.valid;
        idx_d   = above_i.idx;
        val_d   = above_i.val;
        load    = 1'b1;
      end
      OP_POP: begin
        valid_d = below_i.valid;
        idx_d   = below_i.idx;
        val_d   = below_i.val;
        load    = 1'b1;
      end
      OP_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      idx_q <= idx_d;
      val_q <= val_d;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.idx   = idx_q;
  assign entry_o.val   = val_q;

endmodule

// ----- rtl/next_greater_distance_stack.sv -----
// next greater distance stack: top level with sequencer and cell chain
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+----------------------------------------------
//  input   | in_valid_i   | in_ready_o   | sample_value_i, end_of_sequence_i
//  output  | out_valid_o  | out_ready_i  | day_index_o, wait_days_o, last_of_run_o,
//          |              |              | overflow_seen_o
//
// an item is accepted, then pops its entries one at a time through the top cell
// of the chain, and then pushes the new sample
// each pop needs a free output register, so a stalled output holds the pops
// reset empties the chain, clears the day counter and the overflow flag
// an item with end_of_sequence clears the chain instead of pushing

`include "next_greater_distance_stack_macros.svh"

module next_greater_distance_stack
  import ngd_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [DataW-1:0] sample_value_i,
  input  logic                    end_of_sequence_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DataW-1:0]        day_index_o,
  output logic [DataW-1:0]        wait_days_o,
  output logic                    last_of_run_o,
  output logic                    overflow_seen_o
);

  localparam logic [DataW-1:0] DayMax = '1;

  ngd_state_e              state_q, state_d;
  ngd_op_e                 op;
  ngd_entry_t              stack [STACK_DEPTH];
  ngd_entry_t              new_entry;
  ngd_entry_t              empty_entry;

  logic signed [DataW-1:0] sample_q;
  logic                    eos_q;
  logic [DataW-1:0]        day_q, day_d;
  logic                    flag_q, flag_d;
  logic                    flag_in_q;

  logic                    out_valid_q, out_valid_d;
  logic [DataW-1:0]        out_idx_q;
  logic [DataW-1:0]        out_wait_q;
  logic                    out_last_q;
  logic                    out_flag_q;

  logic                    in_fire;
  logic                    out_free;
  logic                    top_pops;
  logic                    next_pops;
  logic                    emit;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // compares against the two top cells
  assign top_pops  = stack[0].valid && (stack[0].val < sample_q);
  assign next_pops = stack[1].valid && (stack[1].val < sample_q);

  assign new_entry.valid   = 1'b1;
  assign new_entry.idx     = day_q;
  assign new_entry.val     = sample_q;
  assign empty_entry       = '0;

  // sequencer: next state and chain operation
  always_comb begin
    state_d     = state_q;
    op          = OP_HOLD;
    emit        = 1'b0;
    day_d       = day_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (top_pops) begin
          if (out_free) begin
            op          = OP_POP;
            emit        = 1'b1;
            out_valid_d = 1'b1;
          end
        end else begin
          state_d = ST_IDLE;
          if (eos_q) begin
            op     = OP_CLEAR;
            day_d  = '0;
            flag_d = 1'b0;
          end else begin
            op = OP_PUSH;
            if (stack[STACK_DEPTH-1].valid) begin
              flag_d = 1'b1;
            end
            if (day_q == DayMax) begin
              flag_d = 1'b1;
            end else begin
              day_d = day_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      day_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      day_q       <= day_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  // captured input word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q  <= sample_value_i;
      eos_q     <= end_of_sequence_i;
      flag_in_q <= flag_q;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_idx_q  <= stack[0].idx;
      out_wait_q <= day_q - stack[0].idx;
      out_last_q <= !next_pops;
      out_flag_q <= flag_in_q;
    end
  end

  // chain of stack cells, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    ngd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .above_i ((i == 0) ? new_entry : stack[(i == 0) ? 0 : i-1]),
      .below_i ((i == STACK_DEPTH-1) ? empty_entry
                                     : stack[(i == STACK_DEPTH-1) ? i : i+1]),
      .entry_o (stack[i])
    );
  end

  assign out_valid_o     = out_valid_q;
  assign day_index_o     = out_idx_q;
  assign wait_days_o     = out_wait_q;
  assign last_of_run_o   = out_last_q;
  assign overflow_seen_o = out_flag_q;

  // occupied cells stay packed against the top
  `NGD_ASSERT_NEVER(a_packed, stack[1].valid && !stack[0].valid)
  // a zero distance only after the day counter saturated or the chain overflowed
  `NGD_ASSERT(a_wait_nonzero, out_valid_o |-> (wait_days_o != '0 || overflow_seen_o))
  // end of sequence leaves an empty chain and a cleared counter
  `NGD_ASSERT(a_eos_clear, (op == OP_CLEAR) |=> (!stack[0].valid && day_q == '0 && !flag_q))
  // a pop never overwrites a word still waiting at the output
  `NGD_ASSERT_NEVER(a_no_overrun, emit && out_valid_q && !out_ready_i)

endmodule
